FILE: src/ldfe_pkg.sv
// shared constants, types and helpers of the labelled decimal field extractor
`default_nettype none

package ldfe_pkg;

    localparam int LABEL_COUNT     = 4;
    localparam int MAX_LABEL_CHARS = 8;
    localparam int FRACTION_DIGITS = 3;

    localparam int CHAR_W     = 8;
    localparam int LABEL_W    = 64;
    localparam int LEN_W      = 4;
    localparam int LENGTHS_W  = LEN_W * LABEL_COUNT;
    localparam int WIN_W      = CHAR_W * MAX_LABEL_CHARS;
    localparam int FILL_W     = $clog2(MAX_LABEL_CHARS + 1);
    localparam int MAG_W      = 47;
    localparam int VALUE_W    = MAG_W + 1;
    localparam int SUM_W      = MAG_W + 5;
    localparam int FC_W       = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam int FRAC_SLOTS = (FRACTION_DIGITS > 0) ? FRACTION_DIGITS : 1;
    localparam int CFG_IDX_W  = $clog2(LABEL_COUNT + 1);
    localparam int CFG_DATA_W = LABEL_W;

    // register indexes: label texts take 0 .. LABEL_COUNT-1
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_LENGTHS = CFG_IDX_W'(LABEL_COUNT);

    localparam logic [LABEL_W-1:0] LABEL_RESET [4] = '{
        64'h0000_0000_414C_543A,
        64'h0000_0000_5645_4C3A,
        64'h0000_0054_454D_503A,
        64'h0000_5052_4553_533A
    };
    localparam logic [LENGTHS_W-1:0] LENGTHS_RESET = LENGTHS_W'(16'h6544);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic                    accept;
        logic                    line_end;
        logic [CHAR_W-1:0]       character;
        logic [WIN_W-1:0]        window;
        logic [FILL_W-1:0]       fill;
    } lane_step_t;

    typedef struct packed {
        value_t value;
        logic   found;
    } lane_result_t;

    typedef struct packed {
        value_t [LABEL_COUNT-1:0] value;
        logic   [LABEL_COUNT-1:0] found;
    } result_t;

    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < 7; k++)
        begin
            if (k < n)
            begin
                p = p * 64'd10;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: src/ldfe_in_if.sv
// character item channel
`default_nettype none

interface ldfe_in_if
    import ldfe_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              line_end;

    modport source (output valid, output character, output line_end, input ready);
    modport sink   (input valid, input character, input line_end, output ready);
endinterface

`default_nettype wire

FILE: src/ldfe_out_if.sv
// result item channel
`default_nettype none

interface ldfe_out_if
    import ldfe_pkg::*;
    ();
    logic   valid;
    logic   ready;
    value_t value_0;
    value_t value_1;
    value_t value_2;
    value_t value_3;
    logic   found_0;
    logic   found_1;
    logic   found_2;
    logic   found_3;

    modport source (output valid, output value_0, output value_1, output value_2,
                    output value_3, output found_0, output found_1, output found_2,
                    output found_3, input ready);
    modport sink   (input valid, input value_0, input value_1, input value_2,
                    input value_3, input found_0, input found_1, input found_2,
                    input found_3, output ready);
endinterface

`default_nettype wire

FILE: src/ldfe_lane.sv
// one label lane: label match on the window and decimal number parser
`default_nettype none

module ldfe_lane
    import ldfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lane_step_t           step,
    input  wire logic [LABEL_W-1:0]   label_text,
    input  wire logic [LEN_W-1:0]     label_len,
    output lane_result_t              result
);

    typedef enum logic [1:0] {PH_IDLE, PH_PRE, PH_DIGITS, PH_DONE} phase_t;

    phase_t            phase_reg, phase_next;
    logic              found_reg, found_next;
    logic              negative_reg, negative_next;
    logic              after_dot_reg, after_dot_next;
    logic [MAG_W-1:0]  acc_reg, acc_next;
    logic [FC_W-1:0]   frac_count_reg, frac_count_next;

    logic [LEN_W-1:0]  len_clamped;
    logic [FILL_W-1:0] len_eff;
    logic              mismatch;
    logic              match;
    logic              take;
    logic              digit;
    logic [3:0]        digit_value;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  frac_addend;
    logic [VALUE_W-1:0] mag_ext;

    // effective label length and window compare
    always_comb
    begin
        if (label_len == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (label_len > LEN_W'(MAX_LABEL_CHARS))
        begin
            len_clamped = LEN_W'(MAX_LABEL_CHARS);
        end
        else
        begin
            len_clamped = label_len;
        end
        len_eff  = FILL_W'(len_clamped);
        mismatch = 1'b0;
        for (int k = 0; k < MAX_LABEL_CHARS; k++)
        begin
            if (FILL_W'(k) < len_eff &&
                step.window[CHAR_W*k +: CHAR_W] != label_text[CHAR_W*k +: CHAR_W])
            begin
                mismatch = 1'b1;
            end
        end
        match = (step.fill >= len_eff) && !mismatch;
    end

    // number parser
    always_comb
    begin
        phase_next      = phase_reg;
        found_next      = found_reg;
        negative_next   = negative_reg;
        after_dot_next  = after_dot_reg;
        acc_next        = acc_reg;
        frac_count_next = frac_count_reg;
        take            = 1'b0;
        sum             = '0;
        frac_addend     = '0;
        digit           = step.character inside {[CH_ZERO:CH_NINE]};
        digit_value     = 4'(step.character - CH_ZERO);

        case (phase_reg)
            PH_PRE:
            begin
                if (step.character != CH_SPACE)
                begin
                    phase_next = PH_DIGITS;
                    if (step.character == CH_MINUS)
                    begin
                        negative_next = 1'b1;
                    end
                    else if (step.character != CH_PLUS)
                    begin
                        take = 1'b1;
                    end
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase

        for (int k = 0; k < FRAC_SLOTS; k++)
        begin
            if (frac_count_reg == FC_W'(k))
            begin
                frac_addend = SUM_W'(digit_value) *
                              SUM_W'(pow10(FRACTION_DIGITS - 1 - k));
            end
        end

        if (take)
        begin
            if (step.character == CH_DOT)
            begin
                after_dot_next = 1'b1;
            end
            else if (digit)
            begin
                if (!after_dot_reg)
                begin
                    sum = SUM_W'(acc_reg) * SUM_W'(10) +
                          SUM_W'(digit_value) * SUM_W'(pow10(FRACTION_DIGITS));
                    acc_next = (sum > SUM_W'(MAG_MAX)) ? MAG_MAX : sum[MAG_W-1:0];
                end
                else if (frac_count_reg < FC_W'(FRACTION_DIGITS))
                begin
                    sum = SUM_W'(acc_reg) + frac_addend;
                    acc_next = (sum > SUM_W'(MAG_MAX)) ? MAG_MAX : sum[MAG_W-1:0];
                    frac_count_next = frac_count_reg + FC_W'(1);
                end
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (!found_reg && match)
        begin
            found_next = 1'b1;
            phase_next = PH_PRE;
        end

        mag_ext      = {1'b0, acc_next};
        result.value = negative_next ? $signed(~mag_ext + VALUE_W'(1)) : $signed(mag_ext);
        result.found = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            found_reg      <= 1'b0;
            negative_reg   <= 1'b0;
            after_dot_reg  <= 1'b0;
            acc_reg        <= '0;
            frac_count_reg <= '0;
        end
        else if (step.accept)
        begin
            if (step.line_end)
            begin
                phase_reg      <= PH_IDLE;
                found_reg      <= 1'b0;
                negative_reg   <= 1'b0;
                after_dot_reg  <= 1'b0;
                acc_reg        <= '0;
                frac_count_reg <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                found_reg      <= found_next;
                negative_reg   <= negative_next;
                after_dot_reg  <= after_dot_next;
                acc_reg        <= acc_next;
                frac_count_reg <= frac_count_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/labelled_decimal_field_extractor.sv
// top level: label window, four parser lanes, config registers, result buffer
// result: the result of a line_end item is registered into the result buffer when the item is accepted
// throughput: one character item per cycle while the spare result entry is empty
// results sit in a two-entry buffer, so input is held off only when both are full
// reset: labels return to their defaults, line state and result buffer are cleared
`default_nettype none

module labelled_decimal_field_extractor
    import ldfe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ldfe_in_if.sink                    line_chars,
    ldfe_out_if.source                 fields
);

    logic [LABEL_W-1:0]   label_text_reg [LABEL_COUNT];
    logic [LENGTHS_W-1:0] label_lengths_reg;

    logic [WIN_W-1:0]     window_reg, window_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;

    logic                 accept;
    logic                 push;
    logic                 pop;
    lane_step_t           step;
    lane_result_t         lane_res [LABEL_COUNT];
    result_t              result_new;

    result_t              out_reg, out_next;
    result_t              skid_reg, skid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    // config registers
    for (genvar g = 0; g < LABEL_COUNT; g++)
    begin : g_label
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                label_text_reg[g] <= LABEL_RESET[g];
            end
            else if (cfg_write && cfg_index == CFG_IDX_W'(g))
            begin
                label_text_reg[g] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_lengths_reg <= LENGTHS_RESET;
        end
        else if (cfg_write && cfg_index == CFG_LABEL_LENGTHS)
        begin
            label_lengths_reg <= cfg_data[LENGTHS_W-1:0];
        end
    end

    // character window
    assign accept           = line_chars.valid && line_chars.ready;
    assign line_chars.ready = !skid_valid_reg;
    assign window_next      = {window_reg[WIN_W-CHAR_W-1:0], line_chars.character};
    assign fill_next        = (fill_reg == FILL_W'(MAX_LABEL_CHARS)) ?
                              fill_reg : fill_reg + FILL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= line_chars.line_end ? '0 : window_next;
            fill_reg   <= line_chars.line_end ? '0 : fill_next;
        end
    end

    always_comb
    begin
        step.accept    = accept;
        step.line_end  = line_chars.line_end;
        step.character = line_chars.character;
        step.window    = window_next;
        step.fill      = fill_next;
    end

    // parser lanes
    for (genvar g = 0; g < LABEL_COUNT; g++)
    begin : g_lane
        ldfe_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (step),
            .label_text (label_text_reg[g]),
            .label_len  (label_lengths_reg[LEN_W*g +: LEN_W]),
            .result     (lane_res[g])
        );
        assign result_new.value[g] = lane_res[g].value;
        assign result_new.found[g] = lane_res[g].found;
    end

    // two-entry result buffer
    assign push = accept && line_chars.line_end;
    assign pop  = out_valid_reg && fields.ready;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = result_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign fields.valid   = out_valid_reg;
    assign fields.value_0 = out_reg.value[0];
    assign fields.value_1 = out_reg.value[1];
    assign fields.value_2 = out_reg.value[2];
    assign fields.value_3 = out_reg.value[3];
    assign fields.found_0 = out_reg.found[0];
    assign fields.found_1 = out_reg.found[1];
    assign fields.found_2 = out_reg.found[2];
    assign fields.found_3 = out_reg.found[3];

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare result entry full while head is empty");

    a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("line end item gave no result");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (fill_reg == '0 && window_reg == '0))
        else $error("window not cleared after line end");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_LABEL_CHARS))
        else $error("window fill count out of range");

endmodule

`default_nettype wire

FILE: tb/sv/tb_labelled_decimal_field_extractor.sv
`timescale 1ns / 1ps
// self-checking bench: directed and random telemetry lines against a table or a predictor
module tb_labelled_decimal_field_extractor;
    import ldfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_LABEL_LENGTHS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;
    localparam logic [63:0]          MAG_LIMIT       = {{(64 - MAG_W){1'b0}}, MAG_MAX};
    localparam longint unsigned      UNIT            = 10 ** FRACTION_DIGITS;
    localparam logic [CHAR_W-1:0]    CH_SEMI         = ";";
    localparam logic [CHAR_W-1:0]    CH_NEWLINE      = 8'h0A;
    localparam logic [CHAR_W-1:0]    NUL_STAND_IN    = "~";
    localparam logic [CHAR_W-1:0]    FF_STAND_IN     = "|";
    localparam int                   PHASES          = 7;
    localparam int                   PHASE_CHARS     = 80;
    localparam int                   DIR_ROWS        = 21;

    typedef enum logic [1:0] {SCAN, LEAD, NUMBER, CLOSED} lane_phase_e;
    typedef enum int {SET_DEFAULT, SET_SHORTEST, SET_LONGEST, SET_MIXED, SET_RAW} label_set_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ldfe_in_if  line_chars ();
    ldfe_out_if fields ();

    labelled_decimal_field_extractor dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .line_chars (line_chars),
        .fields     (fields)
    );

    logic [LABEL_W-1:0]   label_text_m [LABEL_COUNT];
    logic [LENGTHS_W-1:0] lengths_m;
    logic [WIN_W-1:0]     recent_chars;
    int unsigned          recent_fill;
    bit                   lane_hit [LABEL_COUNT];
    lane_phase_e          lane_state [LABEL_COUNT];
    bit                   lane_minus [LABEL_COUNT];
    bit                   lane_frac [LABEL_COUNT];
    logic [63:0]          lane_mag [LABEL_COUNT];
    int unsigned          lane_frac_digits [LABEL_COUNT];

    result_t              expected_fields [$];
    logic [CHAR_W-1:0]    line_buf [$];
    bit                   steady;
    int                   errors;

    // "~" stands for NUL and "|" for 8'hFF
    string dir_text [DIR_ROWS] = '{
        "\n",
        "ALT:123;VEL:-4.5;TEMP:+0.001;PRESS:99\n",
        "VEL:",
        "ALT:1 ALT:2\n",
        "ALT:   42\n",
        "ALT:-+5\n",
        "VEL:- 5\n",
        "TEMP:1.2.3.4\n",
        "PRESS:..5\n",
        "ALT:0.123456\n",
        "ALT:99999999999999999999\n",
        "VEL:-99999999999999999999\n",
        "ALT:12~3\n",
        "ALT:1A",
        "LT:7\n",
        "ALT:12",
        "ALT:;PRESS:|5\n",
        "TEMP:TEMP:5\n",
        "xTEMP:-.75 PRESSURE ALT:+8VEL:3\n",
        "PRESS: +.5e3;ALT:7.\n",
        "VEL:0000000000000001.999;TEMP:-0\n"
    };
    bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0};
    longint dir_value [DIR_ROWS][LABEL_COUNT] = '{
        '{0, 0, 0, 0},
        '{123000, -4500, 1, 99000},
        '{0, 0, 0, 0},
        '{1000, 0, 0, 0},
        '{42000, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 1234, 0},
        '{0, 0, 0, 500},
        '{123, 0, 0, 0},
        '{64'sd140737488355327, 0, 0, 0},
        '{0, -64'sd140737488355327, 0, 0},
        '{12000, 0, 0, 0},
        '{1000, 0, 0, 0},
        '{0, 0, 0, 0},
        '{12000, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 0, 0},
        '{0, 0, 0, 0}
    };
    logic [LABEL_COUNT-1:0] dir_found [DIR_ROWS] = '{
        4'b0000, 4'b1111, 4'b0010, 4'b0001, 4'b0001, 4'b0001, 4'b0010,
        4'b0100, 4'b1000, 4'b0001, 4'b0001, 4'b0010, 4'b0001, 4'b0001,
        4'b0000, 4'b0001, 4'b1001, 4'b0100, 4'b0000, 4'b0000, 4'b0000
    };

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_char(logic [CHAR_W-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void forget_line();
        recent_chars = '0;
        recent_fill  = 0;
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            lane_hit[i]         = 1'b0;
            lane_state[i]       = SCAN;
            lane_minus[i]       = 1'b0;
            lane_frac[i]        = 1'b0;
            lane_mag[i]         = '0;
            lane_frac_digits[i] = 0;
        end
    endfunction

    function automatic int label_span(int i);
        int n;
        n = lengths_m[LEN_W*i +: LEN_W];
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_LABEL_CHARS)
        begin
            n = MAX_LABEL_CHARS;
        end
        return n;
    endfunction

    function automatic bit label_seen(int i);
        int          span;
        logic [63:0] mask;
        span = label_span(i);
        if (recent_fill < span)
        begin
            return 1'b0;
        end
        mask = (span >= 8) ? '1 : ((64'd1 << (8 * span)) - 64'd1);
        return ((recent_chars ^ label_text_m[i]) & mask) == '0;
    endfunction

    function automatic void shift_in_digit(int i, int unsigned d);
        logic [63:0]     sum;
        longint unsigned place;
        if (!lane_frac[i])
        begin
            sum = lane_mag[i] * 64'd10 + d * UNIT;
        end
        else
        begin
            if (lane_frac_digits[i] >= FRACTION_DIGITS)
            begin
                return;
            end
            place = UNIT;
            for (int k = 0; k <= lane_frac_digits[i]; k++)
            begin
                place = place / 10;
            end
            sum = lane_mag[i] + d * place;
            lane_frac_digits[i]++;
        end
        lane_mag[i] = (sum > MAG_LIMIT) ? MAG_LIMIT : sum;
    endfunction

    function automatic void feed_lane(int i, logic [CHAR_W-1:0] c);
        bit is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (lane_state[i] == LEAD)
        begin
            if (c == CH_SPACE)
            begin
                return;
            end
            lane_state[i] = NUMBER;
            if (c == CH_MINUS)
            begin
                lane_minus[i] = 1'b1;
                return;
            end
            if (c == CH_PLUS)
            begin
                return;
            end
        end
        else if (lane_state[i] != NUMBER)
        begin
            return;
        end
        if (c == CH_DOT)
        begin
            lane_frac[i] = 1'b1;
        end
        else if (is_digit)
        begin
            shift_in_digit(i, c - CH_ZERO);
        end
        else
        begin
            lane_state[i] = CLOSED;
        end
    endfunction

    function automatic void predict_char(input logic [CHAR_W-1:0] c, input bit last,
                                         output bit done, output result_t r);
        logic [63:0] v;
        recent_chars = {recent_chars[WIN_W-CHAR_W-1:0], c};
        if (recent_fill < MAX_LABEL_CHARS)
        begin
            recent_fill++;
        end
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            feed_lane(i, c);
            if (!lane_hit[i] && label_seen(i))
            begin
                lane_hit[i]   = 1'b1;
                lane_state[i] = LEAD;
            end
        end
        done = last;
        r    = '0;
        if (last)
        begin
            for (int i = 0; i < LABEL_COUNT; i++)
            begin
                v            = lane_minus[i] ? (64'd0 - lane_mag[i]) : lane_mag[i];
                r.value[i]   = v[VALUE_W-1:0];
                r.found[i]   = lane_hit[i];
            end
            forget_line();
        end
    endfunction

    function automatic logic [LABEL_W-1:0] letter_label(int n);
        logic [LABEL_W-1:0] w;
        w = '0;
        for (int k = 0; k < n; k++)
        begin
            w = {w[LABEL_W-CHAR_W-1:0],
                 (k == n - 1 && n > 1) ? 8'h3A : 8'(8'h41 + $urandom_range(0, 25))};
        end
        return w;
    endfunction

    function automatic void push_label(int i, int keep);
        int span;
        span = label_span(i);
        for (int k = span - 1; k >= span - keep; k--)
        begin
            add_char(label_text_m[i][CHAR_W*k +: CHAR_W]);
        end
    endfunction

    function automatic void build_line();
        int pieces;
        int roll;
        int lane;
        int digits;
        line_buf.delete();
        pieces = $urandom_range(1, 5);
        for (int p = 0; p < pieces; p++)
        begin
            roll = $urandom_range(0, 99);
            lane = $urandom_range(0, LABEL_COUNT - 1);
            if (roll < 70)
            begin
                push_label(lane, label_span(lane));
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3)) add_char(CH_SPACE);
                end
                case ($urandom_range(0, 3))
                    0: add_char(CH_MINUS);
                    1: add_char(CH_PLUS);
                    default: ;
                endcase
                digits = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 22)
                                                      : $urandom_range(0, 6);
                for (int k = 0; k < digits; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        add_char(CH_DOT);
                    end
                    add_char(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                case ($urandom_range(0, 5))
                    0, 1, 2: add_char(CH_SEMI);
                    3: add_char(CH_SPACE);
                    4: add_char(CH_NEWLINE);
                    default: ;
                endcase
            end
            else if (roll < 85)
            begin
                repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                push_label(lane, $urandom_range(1, label_span(lane)));
                add_char(CH_MINUS);
                add_char($urandom_range(0, 1) ? CH_PLUS : CH_SPACE);
                add_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end
        end
        if ($urandom_range(0, 1))
        begin
            add_char(CH_NEWLINE);
        end
    endfunction

    function automatic void check_field(string name, value_t want, value_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && fields.valid === 1'b1 && fields.ready === 1'b1)
        begin
            if (expected_fields.size() == 0)
            begin
                $error("result item with no line pending");
                errors++;
            end
            else
            begin
                want = expected_fields.pop_front();
                check_field("value_0", want.value[0], fields.value_0);
                check_field("value_1", want.value[1], fields.value_1);
                check_field("value_2", want.value[2], fields.value_2);
                check_field("value_3", want.value[3], fields.value_3);
                check_field("found_0", value_t'(want.found[0]), value_t'(fields.found_0));
                check_field("found_1", value_t'(want.found[1]), value_t'(fields.found_1));
                check_field("found_2", value_t'(want.found[2]), value_t'(fields.found_2));
                check_field("found_3", value_t'(want.found[3]), value_t'(fields.found_3));
            end
        end
    end

    initial
    begin
        int run;
        int stall;
        forever
        begin
            fields.ready <= 1'b1;
            run   = $urandom_range(1, 12);
            stall = pick_gap();
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                fields.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx < LABEL_COUNT)
        begin
            label_text_m[idx] = data;
        end
        else if (idx == CFG_LABEL_LENGTHS)
        begin
            lengths_m = data[LENGTHS_W-1:0];
        end
    endtask

    task automatic load_labels(input label_set_e kind);
        logic [LENGTHS_W-1:0]  spans;
        logic [CFG_DATA_W-1:0] text;
        int                    n;
        spans = '0;
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            case (kind)
                SET_DEFAULT:  text = LABEL_RESET[i];
                SET_SHORTEST: text = {$urandom, $urandom};
                SET_LONGEST:  text = (i == 0) ? '1 : (i == 1) ? '0 : letter_label(8);
                SET_MIXED:
                begin
                    n                         = $urandom_range(1, MAX_LABEL_CHARS);
                    text                      = letter_label(n);
                    spans[LEN_W*i +: LEN_W]   = LEN_W'(n);
                end
                default:      text = {$urandom, $urandom};
            endcase
            write_reg(CFG_IDX_W'(i), text);
        end
        case (kind)
            SET_DEFAULT:  spans = LENGTHS_RESET;
            SET_SHORTEST: spans = '0;
            SET_LONGEST:  spans = '1;
            SET_RAW:      spans = LENGTHS_W'($urandom);
            default: ;
        endcase
        text                  = {$urandom, $urandom};
        text[LENGTHS_W-1:0]   = spans;
        write_reg(CFG_LABEL_LENGTHS, text);
        write_reg(CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(0, CFG_SPARE_LAST - CFG_SPARE_FIRST)),
                  {$urandom, $urandom});
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit last, input bit typed,
                             input result_t typed_res);
        result_t r;
        bit      done;
        int      gap;
        line_chars.valid     <= 1'b1;
        line_chars.character <= c;
        line_chars.line_end  <= last;
        do
        begin
            @(posedge clk);
        end
        while (line_chars.ready !== 1'b1);
        predict_char(c, last, done, r);
        if (done)
        begin
            expected_fields.insert(expected_fields.size(), typed ? typed_res : r);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            line_chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input bit typed, input result_t typed_res);
        for (int k = 0; k < line_buf.size(); k++)
        begin
            send_char(line_buf[k], k == line_buf.size() - 1, typed, typed_res);
        end
    endtask

    task automatic run_lines(input int chars);
        int sent;
        sent = 0;
        while (sent < chars)
        begin
            build_line();
            sent += line_buf.size();
            send_line(1'b0, '0);
        end
    endtask

    task automatic drain();
        line_chars.valid <= 1'b0;
        while (expected_fields.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        result_t           typed_res;
        logic [CHAR_W-1:0] ch;
        label_set_e        plan [PHASES];
        plan   = '{SET_DEFAULT, SET_SHORTEST, SET_LONGEST, SET_MIXED, SET_RAW, SET_MIXED,
                   SET_DEFAULT};
        errors = 0;
        steady = 1'b0;
        rst_n                <= 1'b0;
        cfg_write            <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        line_chars.valid     <= 1'b0;
        line_chars.character <= '0;
        line_chars.line_end  <= 1'b0;
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            label_text_m[i] = LABEL_RESET[i];
        end
        lengths_m = LENGTHS_RESET;
        forget_line();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++)
        begin
            line_buf.delete();
            for (int k = 0; k < dir_text[row].len(); k++)
            begin
                ch = dir_text[row][k];
                if (ch == NUL_STAND_IN)
                begin
                    ch = 8'h00;
                end
                else if (ch == FF_STAND_IN)
                begin
                    ch = 8'hFF;
                end
                add_char(ch);
            end
            for (int i = 0; i < LABEL_COUNT; i++)
            begin
                typed_res.value[i] = value_t'(dir_value[row][i]);
            end
            typed_res.found = dir_found[row];
            send_line(dir_typed[row], typed_res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            load_labels(plan[p]);
            steady = (p == PHASES - 2);
            run_lines(PHASE_CHARS);
        end
        drain();
        repeat (8) @(posedge clk);

        if (errors == 0)
        begin
            $display("labelled_decimal_field_extractor: match");
        end
        else
        begin
            $display("labelled_decimal_field_extractor: mismatch");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("labelled_decimal_field_extractor: mismatch");
        $finish;
    end

endmodule
